[rtl/wpcp_pkg.sv]
// shared types, constants and codes for the wav pcm chunk parser
package wpcp_pkg;

   // width of the byte position counter and of the stored payload offset
   localparam int LENGTH_BITS = 32;

   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam int MIN_FILE_BYTES = 44;
   localparam int MIN_FMT_BYTES  = 16;

   localparam logic [1:0] CSR_EXPECTED_RATE          = 2'd0;
   localparam logic [1:0] CSR_EXPECTED_CHANNEL_COUNT = 2'd1;
   localparam logic [1:0] CSR_EXPECTED_SAMPLE_BITS   = 2'd2;

   typedef enum logic [1:0] {
      PHASE_HEAD = 2'd0,
      PHASE_BODY = 2'd1,
      PHASE_PAD  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [31:0] payload_offset;
      logic [31:0] payload_length;
   } rsp_type;

   typedef struct packed {
      logic [31:0] expected_rate;
      logic [15:0] expected_channel_count;
      logic [15:0] expected_sample_bits;
   } cfg_type;

endpackage

[rtl/wpcp_csr.sv]
// configuration registers for the expected audio format
module wpcp_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_data,
   output wpcp_pkg::cfg_type    cfg
);
   import wpcp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_EXPECTED_RATE:          cfg_in.expected_rate          = csr_data;
            CSR_EXPECTED_CHANNEL_COUNT: cfg_in.expected_channel_count = csr_data[15:0];
            CSR_EXPECTED_SAMPLE_BITS:   cfg_in.expected_sample_bits   = csr_data[15:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_rate          <= 32'd16000;
         cfg_ff.expected_channel_count <= 16'd1;
         cfg_ff.expected_sample_bits   <= 16'd16;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/wpcp_core.sv]
// per-byte parse state: tag checks, chunk walk, fmt compare and result
module wpcp_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  wpcp_pkg::req_type    word,
   input  wpcp_pkg::cfg_type    cfg,
   output wpcp_pkg::rsp_type    result
);
   import wpcp_pkg::*;

   localparam logic [LENGTH_BITS-1:0] POS_MAX = '1;

   logic [LENGTH_BITS-1:0] position_ff, position_in;
   logic                   overflow_ff, overflow_in;
   logic                   tags_ok_ff, tags_ok_in;
   phase_type              phase_ff, phase_in;
   logic [2:0]             shift_ff, shift_in;
   logic                   pending_ff, pending_in;
   logic                   format_match_ff, format_match_in;
   logic                   payload_seen_ff, payload_seen_in;
   logic [31:0]            tag_ff, tag_in;
   logic [31:0]            length_ff, length_in;
   logic [31:0]            left_ff, left_in;
   logic [4:0]             body_index_ff, body_index_in;
   logic                   fmt_chunk_ff, fmt_chunk_in;
   logic [LENGTH_BITS-1:0] found_offset_ff, found_offset_in;
   logic [31:0]            found_length_ff, found_length_in;

   logic [7:0]  b;
   logic [31:0] full_len;
   logic [7:0]  exp_byte;
   logic        exp_check;
   logic        ok;

   assign b        = word.file_byte;
   assign full_len = {b, length_ff[23:0]};

   // expected value of the fmt body byte at the current index
   always_comb begin
      exp_byte  = 8'd0;
      exp_check = 1'b1;
      case (body_index_ff)
         5'd0:    exp_byte = 8'd1;
         5'd1:    exp_byte = 8'd0;
         5'd2:    exp_byte = cfg.expected_channel_count[7:0];
         5'd3:    exp_byte = cfg.expected_channel_count[15:8];
         5'd4:    exp_byte = cfg.expected_rate[7:0];
         5'd5:    exp_byte = cfg.expected_rate[15:8];
         5'd6:    exp_byte = cfg.expected_rate[23:16];
         5'd7:    exp_byte = cfg.expected_rate[31:24];
         5'd14:   exp_byte = cfg.expected_sample_bits[7:0];
         5'd15:   exp_byte = cfg.expected_sample_bits[15:8];
         default: exp_check = 1'b0;
      endcase
   end

   always_comb begin
      position_in     = position_ff;
      overflow_in     = overflow_ff;
      tags_ok_in      = tags_ok_ff;
      phase_in        = phase_ff;
      shift_in        = shift_ff;
      pending_in      = pending_ff;
      format_match_in = format_match_ff;
      payload_seen_in = payload_seen_ff;
      tag_in          = tag_ff;
      length_in       = length_ff;
      left_in         = left_ff;
      body_index_in   = body_index_ff;
      fmt_chunk_in    = fmt_chunk_ff;
      found_offset_in = found_offset_ff;
      found_length_in = found_length_ff;

      if (position_ff == POS_MAX) begin
         overflow_in = 1'b1;
      end else begin
         position_in = position_ff + LENGTH_BITS'(1);
         if (position_ff < LENGTH_BITS'(4)) begin
            if (b != TAG_RIFF[8*position_ff[1:0] +: 8]) tags_ok_in = 1'b0;
         end else if (position_ff >= LENGTH_BITS'(8) && position_ff < LENGTH_BITS'(12)) begin
            if (b != TAG_WAVE[8*position_ff[1:0] +: 8]) tags_ok_in = 1'b0;
         end else if (position_ff >= LENGTH_BITS'(12)) begin
            case (phase_ff)
               PHASE_HEAD: begin
                  if (!shift_ff[2]) begin
                     tag_in[8*shift_ff[1:0] +: 8] = b;
                  end else begin
                     length_in[8*shift_ff[1:0] +: 8] = b;
                  end
                  if (shift_ff != 3'd7) begin
                     shift_in = shift_ff + 3'd1;
                  end else begin
                     // header complete: classify the chunk
                     shift_in = 3'd0;
                     if (tag_ff == TAG_FMT && full_len >= 32'(MIN_FMT_BYTES)) begin
                        pending_in = 1'b1;
                     end else if (tag_ff == TAG_DATA) begin
                        payload_seen_in = 1'b1;
                        found_offset_in = position_in;
                        found_length_in = full_len;
                     end
                     fmt_chunk_in  = tag_ff == TAG_FMT && full_len >= 32'(MIN_FMT_BYTES);
                     body_index_in = 5'd0;
                     left_in       = full_len;
                     if (full_len != 32'd0) phase_in = PHASE_BODY;
                  end
               end
               PHASE_BODY: begin
                  if (fmt_chunk_ff) begin
                     if (exp_check && b != exp_byte) pending_in = 1'b0;
                     if (body_index_ff == 5'd15) format_match_in = pending_in;
                  end
                  // index saturates at 16, past the compared fields
                  if (!body_index_ff[4]) body_index_in = body_index_ff + 5'd1;
                  left_in = left_ff - 32'd1;
                  if (left_ff == 32'd1) begin
                     shift_in = 3'd0;
                     phase_in = length_ff[0] ? PHASE_PAD : PHASE_HEAD;
                  end
               end
               default: begin
                  shift_in = 3'd0;
                  phase_in = PHASE_HEAD;
               end
            endcase
         end
      end

      if (word.final_byte) begin
         position_in     = '0;
         overflow_in     = 1'b0;
         tags_ok_in      = 1'b1;
         phase_in        = PHASE_HEAD;
         shift_in        = 3'd0;
         pending_in      = 1'b0;
         format_match_in = 1'b0;
         payload_seen_in = 1'b0;
         found_offset_in = '0;
         found_length_in = 32'd0;
      end
   end

   // size and overflow part of the verdict, from the state ahead of this byte
   always_comb begin
      ok = !overflow_ff && position_ff != POS_MAX
         && position_ff >= LENGTH_BITS'(MIN_FILE_BYTES - 1);
   end

   logic        fin_tags_ok;
   logic        fin_phase_body;
   logic        fin_match;
   logic        fin_seen;
   logic [31:0] fin_length;
   logic [LENGTH_BITS-1:0] fin_offset;

   // state as it stands after this byte, ahead of the end-of-file clear
   always_comb begin
      fin_tags_ok    = tags_ok_ff;
      fin_phase_body = phase_ff == PHASE_BODY;
      fin_match      = format_match_ff;
      fin_seen       = payload_seen_ff;
      fin_length     = found_length_ff;
      fin_offset     = found_offset_ff;
      if (position_ff != POS_MAX) begin
         if (position_ff < LENGTH_BITS'(4)) begin
            fin_tags_ok = tags_ok_ff && b == TAG_RIFF[8*position_ff[1:0] +: 8];
         end else if (position_ff >= LENGTH_BITS'(8) && position_ff < LENGTH_BITS'(12)) begin
            fin_tags_ok = tags_ok_ff && b == TAG_WAVE[8*position_ff[1:0] +: 8];
         end else if (position_ff >= LENGTH_BITS'(12)) begin
            case (phase_ff)
               PHASE_HEAD: begin
                  if (shift_ff == 3'd7) begin
                     fin_phase_body = full_len != 32'd0;
                     if (!(tag_ff == TAG_FMT && full_len >= 32'(MIN_FMT_BYTES))
                         && tag_ff == TAG_DATA) begin
                        fin_seen   = 1'b1;
                        fin_length = full_len;
                        fin_offset = position_ff + LENGTH_BITS'(1);
                     end
                  end
               end
               PHASE_BODY: begin
                  fin_phase_body = left_ff != 32'd1;
                  if (fmt_chunk_ff && body_index_ff == 5'd15) begin
                     fin_match = pending_ff && !(exp_check && b != exp_byte);
                  end
               end
               default: fin_phase_body = 1'b0;
            endcase
         end
      end
   end

   logic fin_ok;
   assign fin_ok = ok && fin_tags_ok && !fin_phase_body && fin_match && fin_seen
      && fin_length != 32'd0 && !fin_length[0]
      && ((LENGTH_BITS <= 32) || ((fin_offset >> 32) == '0));

   assign result.accepted       = fin_ok;
   assign result.payload_offset = fin_ok ? 32'(fin_offset) : 32'd0;
   assign result.payload_length = fin_ok ? fin_length : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff     <= '0;
         overflow_ff     <= 1'b0;
         tags_ok_ff      <= 1'b1;
         phase_ff        <= PHASE_HEAD;
         shift_ff        <= 3'd0;
         pending_ff      <= 1'b0;
         format_match_ff <= 1'b0;
         payload_seen_ff <= 1'b0;
      end else if (step) begin
         position_ff     <= position_in;
         overflow_ff     <= overflow_in;
         tags_ok_ff      <= tags_ok_in;
         phase_ff        <= phase_in;
         shift_ff        <= shift_in;
         pending_ff      <= pending_in;
         format_match_ff <= format_match_in;
         payload_seen_ff <= payload_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         tag_ff          <= tag_in;
         length_ff       <= length_in;
         left_ff         <= left_in;
         body_index_ff   <= body_index_in;
         fmt_chunk_ff    <= fmt_chunk_in;
         found_offset_ff <= found_offset_in;
         found_length_ff <= found_length_in;
      end
   end

   a_body_has_bytes : assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_BODY |-> left_ff != 32'd0)
      else $error("chunk body phase with no bytes left");

   a_new_file_after_final : assert property (@(posedge clock) disable iff (reset)
      step && word.final_byte |=> position_ff == '0 && tags_ok_ff && !payload_seen_ff)
      else $error("parse state not cleared after last word of a file");

endmodule

[rtl/wav_pcm_chunk_parser.sv]
// WAV header parser: one file byte per cycle in while no last byte waits,
// one verdict with payload offset and length out after the word flagged
// as the last of the file. A byte lands in an input register, the parse
// state and verdict are updated from it in one pass of logic, and the verdict
// of a last byte is registered in the result register as that byte moves on.
// A byte flagged as last waits in the input register only while an earlier
// verdict is still held and not taken; all other bytes move on at once.
// The format registers must be written only between files.
module wav_pcm_chunk_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  wpcp_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output wpcp_pkg::rsp_type    rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_data
);
   import wpcp_pkg::*;

   cfg_type cfg;
   rsp_type result;

   logic    in_valid_ff, in_valid_in;
   req_type in_word_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    fire;

   wpcp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   wpcp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (fire),
      .word   (in_word_ff),
      .cfg    (cfg),
      .result (result)
   );

   // only a last word needs room in the result register
   assign fire      = in_valid_ff && (!in_word_ff.final_byte || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) in_valid_in = req_valid;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (fire && in_word_ff.final_byte) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_word_ff <= req_data;
      if (fire && in_word_ff.final_byte) rsp_data_ff <= result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_rsp_from_final : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fire && in_word_ff.final_byte))
      else $error("result word without a last input word");

   a_reject_zeroed : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.accepted
         |-> rsp_data_ff.payload_offset == 32'd0 && rsp_data_ff.payload_length == 32'd0)
      else $error("rejected file reports a payload");

   a_accept_even_length : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.accepted
         |-> rsp_data_ff.payload_length != 32'd0 && !rsp_data_ff.payload_length[0])
      else $error("accepted file with empty or odd payload");

endmodule

[sim/tb_top.sv]
// testbench for wav_pcm_chunk_parser: random wav files checked against a byte-level predictor
module tb_top;
   import wpcp_pkg::*;

   localparam longint unsigned MAX_POSITION = (64'd1 << LENGTH_BITS) - 1;
   localparam int KIND_FMT  = 0;
   localparam int KIND_DATA = 1;
   localparam int KIND_JUNK = 2;
   localparam int NUM_SETTINGS = 6;

   // walks each file byte by byte and keeps the verdicts still to come
   class verdict_board;
      cfg_type         cfg;
      rsp_type         verdicts_due[$];
      longint unsigned position;
      longint unsigned found_off;
      bit              overflow, tags_ok, fmt_match, pend_match, data_seen;
      phase_type       phase;
      bit [31:0]       tag, clen, left, fshift, found_len;
      int              errors, checked, passed_files;

      function new();
         cfg = '{32'd16000, 16'd1, 16'd16};
         clear_file();
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] d);
         case (idx)
            CSR_EXPECTED_RATE:          cfg.expected_rate = d;
            CSR_EXPECTED_CHANNEL_COUNT: cfg.expected_channel_count = d[15:0];
            CSR_EXPECTED_SAMPLE_BITS:   cfg.expected_sample_bits = d[15:0];
            default: ;
         endcase
      endfunction

      function void clear_header();
         phase = PHASE_HEAD;
         tag = 0;
         clen = 0;
         fshift = 0;
      endfunction

      function void clear_file();
         position = 0;
         overflow = 0;
         tags_ok = 1;
         clear_header();
         left = 0;
         fmt_match = 0;
         pend_match = 0;
         data_seen = 0;
         found_off = 0;
         found_len = 0;
      endfunction

      function void walk_chunk(bit [7:0] b, longint unsigned pos);
         bit [31:0] k, idx;
         bit        check, odd;
         bit [7:0]  want;
         case (phase)
            PHASE_HEAD: begin
               k = fshift & 7;
               if (k < 4) tag = tag | (32'(b) << (8 * k));
               else clen = clen | (32'(b) << (8 * (k - 4)));
               if (k != 7) begin
                  fshift = k + 1;
                  return;
               end
               if (tag == TAG_FMT && clen >= MIN_FMT_BYTES) begin
                  pend_match = 1;
               end else if (tag == TAG_DATA) begin
                  data_seen = 1;
                  found_off = pos + 1;
                  found_len = clen;
               end
               if (clen == 0) begin
                  clear_header();
               end else begin
                  phase = PHASE_BODY;
                  left = clen;
               end
            end
            PHASE_BODY: begin
               idx = clen - left;
               if (tag == TAG_FMT && clen >= MIN_FMT_BYTES && idx < 16) begin
                  check = 1;
                  want = 0;
                  if (idx == 0) want = 8'd1;
                  else if (idx == 1) want = 8'd0;
                  else if (idx < 4) want = 8'(cfg.expected_channel_count >> (8 * (idx - 2)));
                  else if (idx < 8) want = 8'(cfg.expected_rate >> (8 * (idx - 4)));
                  else if (idx >= 14) want = 8'(cfg.expected_sample_bits >> (8 * (idx - 14)));
                  else check = 0;
                  if (check && b != want) pend_match = 0;
                  if (idx == 15) fmt_match = pend_match;
               end
               left = left - 1;
               if (left == 0) begin
                  odd = clen[0];
                  clear_header();
                  if (odd) phase = PHASE_PAD;
               end
            end
            default: clear_header();
         endcase
      endfunction

      function void note_byte(req_type r);
         longint unsigned pos;
         bit              ok;
         rsp_type         v;
         pos = position;
         if (pos >= MAX_POSITION) begin
            overflow = 1;
         end else begin
            if (pos < 4) begin
               if (r.file_byte != 8'(TAG_RIFF >> (8 * pos))) tags_ok = 0;
            end else if (pos >= 8 && pos < 12) begin
               if (r.file_byte != 8'(TAG_WAVE >> (8 * (pos - 8)))) tags_ok = 0;
            end else if (pos >= 12) begin
               walk_chunk(r.file_byte, pos);
            end
            position = pos + 1;
         end
         if (!r.final_byte) return;
         ok = !overflow && pos + 1 >= MIN_FILE_BYTES && tags_ok && phase != PHASE_BODY &&
              fmt_match && data_seen && found_len != 0 && !found_len[0] &&
              found_off <= 64'hFFFF_FFFF;
         v.accepted = ok;
         v.payload_offset = ok ? found_off[31:0] : 32'd0;
         v.payload_length = ok ? found_len : 32'd0;
         verdicts_due.push_back(v);
         clear_file();
      endfunction

      function void check_verdict(rsp_type got);
         rsp_type want;
         if (verdicts_due.size() == 0) begin
            $display("%0t: verdict with none due, actual accepted=%0d offset=%0d length=%0d",
                     $time, got.accepted, got.payload_offset, got.payload_length);
            errors++;
            return;
         end
         want = verdicts_due.pop_front();
         checked++;
         if (got.accepted === 1'b1) passed_files++;
         if (got.accepted !== want.accepted) begin
            $display("%0t: accepted mismatch, expected %0d actual %0d",
                     $time, want.accepted, got.accepted);
            errors++;
         end
         if (got.payload_offset !== want.payload_offset) begin
            $display("%0t: payload_offset mismatch, expected %0d actual %0d",
                     $time, want.payload_offset, got.payload_offset);
            errors++;
         end
         if (got.payload_length !== want.payload_length) begin
            $display("%0t: payload_length mismatch, expected %0d actual %0d",
                     $time, want.payload_length, got.payload_length);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_EXPECTED_RATE;
   logic [31:0] csr_data = '0;

   verdict_board board = new();
   cfg_type      cur_cfg = '{32'd16000, 16'd1, 16'd16};
   bit [7:0]     file_q[$];
   bit           last_odd;
   int           burst_left = 0;
   int           stall_hold = 0;
   logic [15:0]  stall_pat = 16'hFFFF;
   int           byte_count = 0;
   int           file_count = 0;

   wav_pcm_chunk_parser i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // values read here are the ones the block saw at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_byte(req_data);
         if (csr_valid && csr_ready) board.write_reg(csr_index, csr_data);
         if (rsp_valid && rsp_ready) board.check_verdict(rsp_data);
      end
   end

   // result side backpressure: a rotating stall pattern redrawn now and then
   always @(posedge clock) begin
      if (stall_hold == 0) begin
         stall_hold <= $urandom_range(20, 200);
         stall_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
         rsp_ready <= 1'b1;
      end else begin
         stall_hold <= stall_hold - 1;
         stall_pat <= {stall_pat[0], stall_pat[15:1]};
         rsp_ready <= stall_pat[0];
      end
   end

   function void put_word(bit [31:0] v);
      for (int i = 0; i < 4; i++) file_q.push_back(v[8 * i +: 8]);
   endfunction

   function bit [7:0] fmt_byte(int i);
      case (i)
         0: return 8'd1;
         1: return 8'd0;
         2, 3: return 8'(cur_cfg.expected_channel_count >> (8 * (i - 2)));
         4, 5, 6, 7: return 8'(cur_cfg.expected_rate >> (8 * (i - 4)));
         14, 15: return 8'(cur_cfg.expected_sample_bits >> (8 * (i - 14)));
         default: return 8'($urandom);
      endcase
   endfunction

   function void put_chunk(int kind);
      int len, start, sel;
      sel = $urandom_range(0, 9);
      case (kind)
         KIND_FMT: begin
            if (sel < 6) len = 16;
            else if (sel == 6) len = 18;
            else if (sel == 7) len = 17;
            else if (sel == 8) len = $urandom_range(19, 40);
            else len = $urandom_range(0, 15);
            put_word(TAG_FMT);
            put_word(32'(len));
            start = file_q.size();
            for (int i = 0; i < len; i++) file_q.push_back(fmt_byte(i));
            // spoil one of the first 16 format bytes now and then
            if (len != 0 && $urandom_range(0, 7) == 0)
               file_q[start + $urandom_range(0, (len < 16 ? len : 16) - 1)] ^=
                  8'(1 << $urandom_range(0, 7));
         end
         KIND_DATA: begin
            if (sel < 7) len = 2 * $urandom_range(1, 6);
            else if (sel == 7) len = 0;
            else if (sel == 8) len = 2 * $urandom_range(0, 11) + 1;
            else len = 2 * $urandom_range(7, 30);
            put_word(TAG_DATA);
            put_word(32'(len));
            for (int i = 0; i < len; i++) file_q.push_back(8'($urandom));
         end
         default: begin
            len = $urandom_range(0, 9);
            put_word($urandom);
            put_word(32'(len));
            for (int i = 0; i < len; i++) file_q.push_back(8'($urandom));
         end
      endcase
      last_odd = len[0];
      if (last_odd) file_q.push_back(8'($urandom));
   endfunction

   function void build_file();
      int sel, n;
      file_q.delete();
      last_odd = 0;
      if ($urandom_range(0, 15) == 0) begin
         n = $urandom_range(1, 60);
         repeat (n) file_q.push_back(8'($urandom));
         return;
      end
      put_word(TAG_RIFF);
      put_word($urandom);
      put_word(TAG_WAVE);
      if ($urandom_range(0, 15) == 0)
         file_q[$urandom_range(0, 11)] ^= 8'(1 << $urandom_range(0, 7));
      if ($urandom_range(0, 3) == 0) put_chunk(KIND_JUNK);
      if ($urandom_range(0, 9) != 0) put_chunk(KIND_FMT);
      if ($urandom_range(0, 4) == 0) put_chunk(KIND_JUNK);
      if ($urandom_range(0, 9) != 0) put_chunk(KIND_DATA);
      if ($urandom_range(0, 3) == 0) put_chunk($urandom_range(KIND_FMT, KIND_JUNK));
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         // file ends inside a body or header
         n = $urandom_range(1, 6);
         if (file_q.size() > n) repeat (n) void'(file_q.pop_back());
      end else if (sel == 1) begin
         // trailing scrap shorter than a chunk header
         n = $urandom_range(1, 7);
         repeat (n) file_q.push_back(8'($urandom));
      end else if (sel == 2 && last_odd) begin
         void'(file_q.pop_back());
      end
   endfunction

   task automatic send_byte(input bit [7:0] b, input bit fin);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_data <= '{file_byte: b, final_byte: fin};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
   endtask

   task automatic play_file();
      for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
      byte_count += file_q.size();
      file_count++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (board.verdicts_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // csr_valid stays high between back-to-back writes
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic write_settings(input cfg_type c);
      wait_idle();
      csr_write(CSR_EXPECTED_RATE, c.expected_rate);
      csr_write(CSR_EXPECTED_CHANNEL_COUNT, 32'(c.expected_channel_count));
      csr_write(CSR_EXPECTED_SAMPLE_BITS, 32'(c.expected_sample_bits));
      csr_valid <= 1'b0;
      cur_cfg = c;
   endtask

   initial begin
      cfg_type settings[NUM_SETTINGS];
      int      phase_items, phase_files;
      settings[0] = '{32'd16000, 16'd1, 16'd16};
      settings[1] = '{32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF};
      settings[2] = '{32'd0, 16'd0, 16'd0};
      settings[3] = '{32'd44100, 16'd2, 16'd24};
      settings[4] = '{$urandom, 16'($urandom), 16'($urandom)};
      settings[5] = '{$urandom, 16'($urandom_range(1, 8)), 16'($urandom_range(8, 32))};
      reset <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < NUM_SETTINGS; p++) begin
         write_settings(settings[p]);
         if (p == 0) begin
            // one-byte files at both byte extremes, then a bare riff/wave header
            file_q = '{8'h00};
            play_file();
            file_q = '{8'hFF};
            play_file();
            file_q.delete();
            put_word(TAG_RIFF);
            put_word(32'hFFFF_FFFF);
            put_word(TAG_WAVE);
            play_file();
         end
         phase_items = 0;
         phase_files = 0;
         while (phase_items < 280 || phase_files < 4) begin
            build_file();
            phase_items += file_q.size();
            phase_files++;
            play_file();
         end
      end
      wait_idle();
      $display("covered %0d file bytes in %0d files under %0d format settings",
               byte_count, file_count, NUM_SETTINGS);
      $display("%0d verdicts checked, %0d of them accepting", board.checked, board.passed_files);
      if (board.errors == 0 && board.verdicts_due.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #800000;
      $display("timeout with %0d verdicts outstanding", board.verdicts_due.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

[sim.f]
rtl/wpcp_pkg.sv
rtl/wpcp_csr.sv
rtl/wpcp_core.sv
rtl/wav_pcm_chunk_parser.sv
sim/tb_top.sv
